@@ rtl/core/lrcp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrcp_pkg
// Shared types and constants of the lidar closest point finder.
// ----------------------------------------------------------------------------
package lrcp_pkg;

    localparam int unsigned TRIG_DEPTH_DEFAULT = 1024;
    localparam int unsigned QUEUE_DEPTH        = 4;
    localparam int unsigned QUANT_LAT          = 2;
    localparam int unsigned SINE_LAT           = 5;
    localparam int unsigned ITEM_STAGES        = QUANT_LAT + SINE_LAT + 2;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DOWNSAMPLE_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH      = 3'd5;

    localparam logic [15:0] RANGE_INF    = 16'hFFFF;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    typedef struct packed {
        logic [7:0]  keep_every;
        logic [15:0] angle_start;
        logic [15:0] angle_step;
        logic [15:0] forward_min_mm;
        logic [15:0] forward_max_mm;
        logic [14:0] half_width_mm;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        keep_every:      8'd5,
        angle_start:     16'hE000,
        angle_step:      16'd182,
        forward_min_mm:  16'd300,
        forward_max_mm:  16'd1000,
        half_width_mm:   15'd500
    };

    typedef struct packed {
        logic        kept;
        logic        last;
        logic        live;
        logic [15:0] range_mm;
    } t_sample;

    typedef struct packed {
        t_sample     smp;
        logic [15:0] angle;
    } t_qent;

    typedef struct packed {
        logic    valid;
        t_sample smp;
    } t_item;

endpackage
`default_nettype wire

@@ rtl/core/lrcp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrcp_queue
// Short register queue between the sample front end and the geometry back end.
// ----------------------------------------------------------------------------
module lrcp_queue
    import lrcp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_data,
    input  wire logic  i_pop,
    output t_qent      o_data,
    output logic       o_full,
    output logic       o_empty
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    t_qent           r_mem [0:QUEUE_DEPTH-1];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/lrcp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrcp_front
// Downsample phase and scan angle tracking; queues kept and scan end samples.
// ----------------------------------------------------------------------------
module lrcp_front
    import lrcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    input  wire logic        i_full,
    input  wire logic [15:0] i_range_mm,
    input  wire logic        i_range_invalid,
    input  wire logic        i_scan_end,
    output logic             o_push,
    output t_qent            o_entry
);

    logic [7:0]  r_phase;
    logic [15:0] r_angle_acc;
    logic [7:0]  n_phase;
    logic [15:0] n_angle_acc;
    logic [7:0]  w_rate;
    logic [8:0]  w_phase_inc;
    logic        w_accept;
    logic        w_kept;

    assign w_accept = i_valid && !i_full;
    assign w_kept   = (r_phase == '0);
    assign w_rate   = (i_cfg.keep_every == '0) ? 8'd1 : i_cfg.keep_every;
    assign w_phase_inc = {1'b0, r_phase} + 9'd1;

    always_comb begin
        n_phase     = (w_phase_inc >= {1'b0, w_rate}) ? 8'd0 : w_phase_inc[7:0];
        n_angle_acc = r_angle_acc + i_cfg.angle_step;
        if (i_scan_end) begin
            n_phase     = '0;
            n_angle_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_angle_acc <= '0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_angle_acc <= n_angle_acc;
        end
    end

    assign o_push               = w_accept && (w_kept || i_scan_end);
    assign o_entry.smp.kept     = w_kept;
    assign o_entry.smp.last     = i_scan_end;
    assign o_entry.smp.live     = w_kept && !i_range_invalid && (i_range_mm != '0);
    assign o_entry.smp.range_mm = i_range_mm;
    assign o_entry.angle        = i_cfg.angle_start + r_angle_acc;

endmodule
`default_nettype wire

@@ rtl/core/lrcp_angle_quant.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrcp_angle_quant
// Snaps a binary angle to the trig grid: k = angle*D >> 16, result k*65536/D
// by a scaled reciprocal multiply, exact for every k below D. Two stages.
// ----------------------------------------------------------------------------
module lrcp_angle_quant
    import lrcp_pkg::*;
#(
    parameter int unsigned TRIG_TABLE_DEPTH = TRIG_DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_angle,
    output logic [15:0]      o_angle
);

    localparam int unsigned KW = (TRIG_TABLE_DEPTH > 1) ? $clog2(TRIG_TABLE_DEPTH) : 1;
    localparam int unsigned PW = 16 + $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int unsigned SH = 2 * KW;
    localparam int unsigned MW = KW + 18;
    localparam int unsigned QW = KW + MW;
    // ceil(2^(16+SH) / D); error stays below one grid step since 2^SH >= D*D
    localparam longint unsigned RECIP_L =
        ((64'd1 << (16 + SH)) + 64'(TRIG_TABLE_DEPTH) - 64'd1) / 64'(TRIG_TABLE_DEPTH);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic [PW-1:0] w_prod;
    logic [QW-1:0] w_quo;
    logic [KW-1:0] r_k;
    logic [15:0]   r_qa;

    assign w_prod = PW'(i_angle) * PW'(TRIG_TABLE_DEPTH);
    assign w_quo  = QW'(r_k) * QW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k  <= w_prod[16 +: KW];
            r_qa <= w_quo[SH +: 16];
        end
    end

    assign o_angle = r_qa;

endmodule
`default_nettype wire

@@ rtl/core/lrcp_sine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrcp_sine
// Pipelined Q15 sine of a binary angle: quadrant fold and odd polynomial,
// one multiply per stage after the fold. Returns magnitude and sign.
// ----------------------------------------------------------------------------
module lrcp_sine
    import lrcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_angle,
    output logic [15:0]      o_mag,
    output logic             o_neg
);

    logic [14:0] w_fold;
    logic [31:0] w_p2;
    logic [31:0] w_p3;
    logic [15:0] w_c4;
    logic [31:0] w_p4;
    logic [15:0] w_c5;
    logic [31:0] w_p5;

    logic [15:0] r_z1, r_z2, r_z3, r_z4;
    logic [15:0] r_sq2, r_sq3;
    logic [11:0] r_t3;
    logic [14:0] r_t4;
    logic [15:0] r_mag5;
    logic        r_neg1, r_neg2, r_neg3, r_neg4, r_neg5;

    assign w_fold = i_angle[14] ? (15'd16384 - {1'b0, i_angle[13:0]})
                                : {1'b0, i_angle[13:0]};
    assign w_p2   = 32'(r_z1) * 32'(r_z1);
    assign w_p3   = 32'd2320 * 32'(r_sq2);
    assign w_c4   = 16'd21024 - 16'(r_t3);
    assign w_p4   = 32'(w_c4) * 32'(r_sq3);
    assign w_c5   = 16'd51472 - 16'(r_t4);
    assign w_p5   = 32'(w_c5) * 32'(r_z4);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1   <= {w_fold, 1'b0};
            r_neg1 <= i_angle[15];

            r_sq2  <= w_p2[30:15];
            r_z2   <= r_z1;
            r_neg2 <= r_neg1;

            r_t3   <= w_p3[26:15];
            r_sq3  <= r_sq2;
            r_z3   <= r_z2;
            r_neg3 <= r_neg2;

            r_t4   <= w_p4[29:15];
            r_z4   <= r_z3;
            r_neg4 <= r_neg3;

            r_mag5 <= w_p5[30:15];
            r_neg5 <= r_neg4;
        end
    end

    assign o_mag = r_mag5;
    assign o_neg = r_neg5;

endmodule
`default_nettype wire

@@ rtl/core/lrcp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrcp_back
// Angle snap, sine and cosine, range scaling, rectangle test, nearest point
// tracking and the result register. The whole pipe advances when the result
// register can take a new value.
// ----------------------------------------------------------------------------
module lrcp_back
    import lrcp_pkg::*;
#(
    parameter int unsigned TRIG_TABLE_DEPTH = TRIG_DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_qent       i_entry,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_sample_kept,
    output logic [15:0]      o_filtered_range_mm,
    output logic             o_summary_valid,
    output logic             o_obstacle_found,
    output logic [15:0]      o_nearest_range_mm,
    output logic [16:0]      o_nearest_x_mm,
    output logic [16:0]      o_nearest_y_mm
);

    localparam int unsigned LAST = ITEM_STAGES - 1;
    localparam int unsigned TRIG_AT = QUANT_LAT + SINE_LAT - 1;

    logic        w_en;
    t_item       r_item [0:LAST];
    t_sample     w_smp;
    logic [15:0] w_qa;
    logic [15:0] w_cos_mag, w_sin_mag;
    logic        w_cos_neg, w_sin_neg;

    logic [31:0] r_prod_x, r_prod_y;
    logic        r_pneg_x, r_pneg_y;
    logic [32:0] w_rnd_x, w_rnd_y;
    logic [15:0] r_vx, r_vy;
    logic        r_vneg_x, r_vneg_y;

    logic signed [16:0] w_x, w_y;
    logic signed [16:0] w_fmin, w_fmax;
    logic               w_hit;
    logic               w_better;
    logic               w_fire;

    logic        r_hit;
    logic [15:0] r_best_range;
    logic [16:0] r_best_x, r_best_y;
    logic        n_hit;
    logic [15:0] n_best_range;
    logic [16:0] n_best_x, n_best_y;

    logic        r_o_valid;
    logic        r_o_kept;
    logic [15:0] r_o_filtered;
    logic        r_o_summary;
    logic        r_o_obstacle;
    logic [15:0] r_o_range;
    logic [16:0] r_o_x, r_o_y;

    assign w_en  = !r_o_valid || !i_stall;
    assign o_pop = w_en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAST; s++) begin
                r_item[s] <= '0;
            end
        end else if (w_en) begin
            r_item[0].valid <= !i_empty;
            r_item[0].smp   <= i_entry.smp;
            for (int s = 1; s <= LAST; s++) begin
                r_item[s] <= r_item[s-1];
            end
        end
    end

    lrcp_angle_quant #(
        .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
    ) u_quant (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_entry.angle),
        .o_angle (w_qa)
    );

    lrcp_sine u_cos (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_qa + QUARTER_TURN),
        .o_mag   (w_cos_mag),
        .o_neg   (w_cos_neg)
    );

    lrcp_sine u_sin (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_qa),
        .o_mag   (w_sin_mag),
        .o_neg   (w_sin_neg)
    );

    // range * trig, then round half away from zero on the magnitude
    assign w_rnd_x = {1'b0, r_prod_x} + 33'd16384;
    assign w_rnd_y = {1'b0, r_prod_y} + 33'd16384;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod_x <= 32'(r_item[TRIG_AT].smp.range_mm) * 32'(w_cos_mag);
            r_prod_y <= 32'(r_item[TRIG_AT].smp.range_mm) * 32'(w_sin_mag);
            r_pneg_x <= w_cos_neg;
            r_pneg_y <= w_sin_neg;
            r_vx     <= w_rnd_x[30:15];
            r_vy     <= w_rnd_y[30:15];
            r_vneg_x <= r_pneg_x;
            r_vneg_y <= r_pneg_y;
        end
    end

    assign w_smp  = r_item[LAST].smp;
    assign w_fire = w_en && r_item[LAST].valid;
    assign w_x    = r_vneg_x ? -$signed({1'b0, r_vx}) : $signed({1'b0, r_vx});
    assign w_y    = r_vneg_y ? -$signed({1'b0, r_vy}) : $signed({1'b0, r_vy});
    assign w_fmin = $signed({i_cfg.forward_min_mm[15], i_cfg.forward_min_mm});
    assign w_fmax = $signed({i_cfg.forward_max_mm[15], i_cfg.forward_max_mm});

    assign w_hit = w_smp.live && (w_x >= w_fmin) && (w_x <= w_fmax)
                   && (r_vy <= {1'b0, i_cfg.half_width_mm});
    assign w_better = w_hit && (!r_hit || (w_smp.range_mm < r_best_range));

    always_comb begin
        n_hit        = r_hit || w_hit;
        n_best_range = r_best_range;
        n_best_x     = r_best_x;
        n_best_y     = r_best_y;
        if (w_better) begin
            n_best_range = w_smp.range_mm;
            n_best_x     = w_x;
            n_best_y     = w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_best_range <= RANGE_INF;
            r_best_x     <= '0;
            r_best_y     <= '0;
        end else if (w_fire) begin
            if (w_smp.last) begin
                r_hit        <= 1'b0;
                r_best_range <= RANGE_INF;
                r_best_x     <= '0;
                r_best_y     <= '0;
            end else begin
                r_hit        <= n_hit;
                r_best_range <= n_best_range;
                r_best_x     <= n_best_x;
                r_best_y     <= n_best_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_item[LAST].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o_kept     <= w_smp.kept;
            r_o_filtered <= w_smp.kept ? (w_hit ? w_smp.range_mm : RANGE_INF) : '0;
            r_o_summary  <= w_smp.last;
            r_o_obstacle <= w_smp.last && n_hit;
            r_o_range    <= w_smp.last ? n_best_range : '0;
            r_o_x        <= w_smp.last ? n_best_x : '0;
            r_o_y        <= w_smp.last ? n_best_y : '0;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_sample_kept       = r_o_kept;
    assign o_filtered_range_mm = r_o_filtered;
    assign o_summary_valid     = r_o_summary;
    assign o_obstacle_found    = r_o_obstacle;
    assign o_nearest_range_mm  = r_o_range;
    assign o_nearest_x_mm      = r_o_x;
    assign o_nearest_y_mm      = r_o_y;

endmodule
`default_nettype wire

@@ rtl/core/lidar_roi_closest_point_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_roi_closest_point_top
// Forward rectangle obstacle finder over a stream of lidar range samples.
//
// Input channel (i_valid / o_stall): one raw range sample per transfer.
// One sample in N of a scan is kept, N set by the keep-rate register; a kept
// sample or a sample flagged i_scan_end yields one result, others yield none.
// Output channel (o_valid / i_stall): one result per transfer; the scan end
// result carries the nearest in-rectangle point and the obstacle flag.
// Config channel (i_cfg_valid / o_cfg_ready): ready is always high; write
// only while the block is idle.
// Throughput: one sample per cycle while o_stall is low. From input transfer
// to o_valid a sample passes the four-entry queue, the 2-stage angle snap
// (it pops the queue once the transfer has written it), the 5-stage sine
// polynomial, two scaling stages and the result register.
// i_stall freezes the back pipe; the four-entry queue then fills and o_stall
// rises.
// Reset (synchronous, active low) restores register defaults, clears the
// scan phase, angle accumulator, nearest point tracking and all valids.
// ----------------------------------------------------------------------------
module lidar_roi_closest_point_top
    import lrcp_pkg::*;
#(
    parameter int unsigned TRIG_TABLE_DEPTH = TRIG_DEPTH_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [15:0]           i_range_mm,
    input  wire logic                  i_range_invalid,
    input  wire logic                  i_scan_end,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_sample_kept,
    output logic [15:0]                o_filtered_range_mm,
    output logic                       o_summary_valid,
    output logic                       o_obstacle_found,
    output logic [15:0]                o_nearest_range_mm,
    output logic [16:0]                o_nearest_x_mm,
    output logic [16:0]                o_nearest_y_mm,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_full;
    logic  w_empty;
    logic  w_push;
    logic  w_pop;
    t_qent w_push_entry;
    t_qent w_head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DOWNSAMPLE_RATE: r_cfg.keep_every      <= i_cfg_data[7:0];
                CFG_ANGLE_START:     r_cfg.angle_start     <= i_cfg_data;
                CFG_ANGLE_STEP:      r_cfg.angle_step      <= i_cfg_data;
                CFG_FORWARD_MIN:     r_cfg.forward_min_mm  <= i_cfg_data;
                CFG_FORWARD_MAX:     r_cfg.forward_max_mm  <= i_cfg_data;
                CFG_HALF_WIDTH:      r_cfg.half_width_mm   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    lrcp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .i_full          (w_full),
        .i_range_mm      (i_range_mm),
        .i_range_invalid (i_range_invalid),
        .i_scan_end      (i_scan_end),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    lrcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lrcp_back #(
        .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_entry             (w_head),
        .i_empty             (w_empty),
        .o_pop               (w_pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_sample_kept       (o_sample_kept),
        .o_filtered_range_mm (o_filtered_range_mm),
        .o_summary_valid     (o_summary_valid),
        .o_obstacle_found    (o_obstacle_found),
        .o_nearest_range_mm  (o_nearest_range_mm),
        .o_nearest_x_mm      (o_nearest_x_mm),
        .o_nearest_y_mm      (o_nearest_y_mm)
    );

endmodule
`default_nettype wire

@@ verif/lidar_roi_closest_point_top_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_roi_closest_point_top_tb
// Self-checking bench for the forward rectangle closest point finder.
//
// A directed table runs first: zero and invalid ranges, rectangle edges, equal
// ranges, scan ends with and without hits, rate changes inside a scan, rate
// zero and an empty rectangle. Random scans then run under several register
// settings, extremes included, with sender gaps and receiver stalls, plus one
// long receiver hold-off that backs the block up. Every result transfer is
// compared field by field against its table entry, if it has one, or else an in-bench model of the sample path.
// ----------------------------------------------------------------------------
module lidar_roi_closest_point_top_tb;
    import lrcp_pkg::*;

    localparam int unsigned TRIG_DEPTH     = TRIG_DEPTH_DEFAULT;
    localparam int          DRAIN_CYCLES   = ITEM_STAGES + QUEUE_DEPTH + 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic        kept;
        logic [15:0] filtered;
        logic        summary;
        logic        obstacle;
        logic [15:0] near_range;
        logic [16:0] near_x;
        logic [16:0] near_y;
    } t_roi_result;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [15:0]           range_mm;
        logic                  invalid;
        logic                  last;
        bit                    typed;
        t_roi_result           want;
    } t_stim_row;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic [15:0]           i_range_mm      = '0;
    logic                  i_range_invalid = 1'b0;
    logic                  i_scan_end      = 1'b0;
    logic                  i_stall         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_sample_kept;
    logic [15:0]           o_filtered_range_mm;
    logic                  o_summary_valid;
    logic                  o_obstacle_found;
    logic [15:0]           o_nearest_range_mm;
    logic [16:0]           o_nearest_x_mm;
    logic [16:0]           o_nearest_y_mm;
    logic                  o_cfg_ready;

    // register copies
    int          cfg_rate  = 5;
    logic [15:0] cfg_start = 16'hE000;
    logic [15:0] cfg_step  = 16'd182;
    int          cfg_fmin  = 300;
    int          cfg_fmax  = 1000;
    int          cfg_hw    = 500;

    // scan state
    int          phase_cnt = 0;
    logic [15:0] ang_acc   = '0;
    logic [15:0] trk_range = 16'hFFFF;
    int          trk_x     = 0;
    int          trk_y     = 0;
    bit          trk_hit   = 1'b0;

    t_roi_result roi_results_due[$];
    t_stim_row   dir_tab[$];
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          hold_req      = 1'b0;
    int          hold_cnt      = 0;
    int          idle_cycles   = 0;

    lidar_roi_closest_point_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_range_mm          (i_range_mm),
        .i_range_invalid     (i_range_invalid),
        .i_scan_end          (i_scan_end),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_sample_kept       (o_sample_kept),
        .o_filtered_range_mm (o_filtered_range_mm),
        .o_summary_valid     (o_summary_valid),
        .o_obstacle_found    (o_obstacle_found),
        .o_nearest_range_mm  (o_nearest_range_mm),
        .o_nearest_x_mm      (o_nearest_x_mm),
        .o_nearest_y_mm      (o_nearest_y_mm),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Q15 sine of a 16-bit binary angle, polynomial per quarter turn
    function automatic int turn_sine(input logic [15:0] ang);
        logic [1:0]      quad;
        longint unsigned r, z, z2, t;
        quad = ang[15:14];
        r    = ang[13:0];
        if (quad[0])
            r = 16384 - r;
        z  = r << 1;
        z2 = (z * z) >> 15;
        t  = (2320 * z2) >> 15;
        t  = ((21024 - t) * z2) >> 15;
        t  = ((51472 - t) * z) >> 15;
        return quad[1] ? -int'(t) : int'(t);
    endfunction

    function automatic logic [15:0] snap_angle(input logic [15:0] ang);
        longint unsigned k;
        k = ang;
        k = (k * TRIG_DEPTH) >> 16;
        return 16'((k << 16) / TRIG_DEPTH);
    endfunction

    // range times Q15 trig, magnitude rounded half away from zero
    function automatic int project(input logic [15:0] rng, input int trig);
        longint unsigned mag;
        int              v;
        mag = longint'(rng) * longint'(trig < 0 ? -trig : trig);
        v   = int'((mag + 16384) >> 15);
        return trig < 0 ? -v : v;
    endfunction

    function automatic bit roi_result_for(input logic [15:0] rng, input logic inv,
                                          input logic last, output t_roi_result res);
        logic [15:0] qa;
        int          x, y, ay, rate;
        bit          kept;
        rate = (cfg_rate == 0) ? 1 : cfg_rate;
        kept = (phase_cnt == 0);
        res  = '0;
        if (kept) begin
            res.kept     = 1'b1;
            res.filtered = RANGE_INF;
            if (!inv && rng != 16'd0) begin
                qa = snap_angle(cfg_start + ang_acc);
                x  = project(rng, turn_sine(qa + QUARTER_TURN));
                y  = project(rng, turn_sine(qa));
                ay = (y < 0) ? -y : y;
                if (x >= cfg_fmin && x <= cfg_fmax && ay <= cfg_hw) begin
                    res.filtered = rng;
                    if (!trk_hit || rng < trk_range) begin
                        trk_range = rng;
                        trk_x     = x;
                        trk_y     = y;
                    end
                    trk_hit = 1'b1;
                end
            end
        end
        phase_cnt = (phase_cnt + 1 >= rate) ? 0 : phase_cnt + 1;
        ang_acc   = ang_acc + cfg_step;
        if (last) begin
            res.summary    = 1'b1;
            res.obstacle   = trk_hit;
            res.near_range = trk_range;
            res.near_x     = 17'(trk_x);
            res.near_y     = 17'(trk_y);
            trk_range      = 16'hFFFF;
            trk_x          = 0;
            trk_y          = 0;
            trk_hit        = 1'b0;
            phase_cnt      = 0;
            ang_acc        = '0;
        end
        return kept || last;
    endfunction

    function automatic void check_field(input string name, input logic [16:0] want,
                                        input logic [16:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row      = '{ROW_CFG, idx, data, 16'd0, 1'b0, 1'b0, 1'b0, '0};
        return row;
    endfunction

    function automatic t_stim_row smp_row(input logic [15:0] rng, input logic inv,
                                          input logic last);
        t_stim_row row;
        row = '{ROW_SAMPLE, '0, '0, rng, inv, last, 1'b0, '0};
        return row;
    endfunction

    function automatic t_stim_row chk_row(input logic [15:0] rng, input logic inv,
                                          input logic last, input t_roi_result want);
        t_stim_row row;
        row = '{ROW_SAMPLE, '0, '0, rng, inv, last, 1'b1, want};
        return row;
    endfunction

    function automatic t_roi_result kept_res(input logic [15:0] filtered);
        return {1'b1, filtered, 1'b0, 1'b0, 16'd0, 17'd0, 17'd0};
    endfunction

    function automatic void add_row(input t_stim_row row);
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_DOWNSAMPLE_RATE: cfg_rate  = int'(data[7:0]);
            CFG_ANGLE_START:     cfg_start = data;
            CFG_ANGLE_STEP:      cfg_step  = data;
            CFG_FORWARD_MIN:     cfg_fmin  = int'(signed'(data));
            CFG_FORWARD_MAX:     cfg_fmax  = int'(signed'(data));
            CFG_HALF_WIDTH:      cfg_hw    = int'(data[14:0]);
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (roi_results_due.size() != 0)
            @(posedge i_clk);
        // samples that yield no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [15:0] rng, input logic inv, input logic last,
                               input bit typed, input t_roi_result typed_res);
        t_roi_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_range_mm      <= rng;
        i_range_invalid <= inv;
        i_scan_end      <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (roi_result_for(rng, inv, last, pred))
            roi_results_due.insert(roi_results_due.size(), typed ? typed_res : pred);
    endtask

    task automatic send_random();
        logic [15:0] rng;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 8)
            rng = 16'd0;
        else if (pick < 14)
            rng = 16'hFFFF;
        else if (pick < 30)
            rng = 16'($urandom);
        else
            rng = 16'($urandom_range(4000, 1));
        send_sample(rng, $urandom_range(99) < 8, $urandom_range(99) < 5, 1'b0, '0);
    endtask

    initial begin : stimulus
        bit                    cfg_batch;
        logic [CFG_DATA_W-1:0] c_rate, c_start, c_step, c_fmin, c_fmax, c_hw;
        int                    lo;
        cfg_batch = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: rate 5, first sample at -45 degrees
        add_row(chk_row(16'd0, 1'b0, 1'b0, kept_res(RANGE_INF)));
        add_row(smp_row(16'hFFFF, 1'b0, 1'b0));
        add_row(smp_row(16'd1234, 1'b1, 1'b0));
        add_row(smp_row(16'd0, 1'b1, 1'b0));
        add_row(smp_row(16'd17, 1'b0, 1'b0));
        add_row(chk_row(16'd500, 1'b1, 1'b0, kept_res(RANGE_INF)));
        add_row(chk_row(16'd800, 1'b0, 1'b1,
            {1'b0, 16'd0, 1'b1, 1'b0, RANGE_INF, 17'd0, 17'd0}));
        add_row(smp_row(16'd1000, 1'b0, 1'b0));
        add_row(smp_row(16'd400, 1'b0, 1'b1));
        // every sample straight ahead: x equals range, y is zero
        add_row(cfg_row(CFG_DOWNSAMPLE_RATE, 16'd1));
        add_row(cfg_row(CFG_ANGLE_START, 16'd0));
        add_row(cfg_row(CFG_ANGLE_STEP, 16'd0));
        add_row(chk_row(16'd300, 1'b0, 1'b0, kept_res(16'd300)));
        add_row(chk_row(16'd1000, 1'b0, 1'b0, kept_res(16'd1000)));
        add_row(chk_row(16'd299, 1'b0, 1'b0, kept_res(RANGE_INF)));
        add_row(chk_row(16'd1001, 1'b0, 1'b0, kept_res(RANGE_INF)));
        add_row(smp_row(16'd300, 1'b0, 1'b0));
        add_row(chk_row(16'd0, 1'b0, 1'b0, kept_res(RANGE_INF)));
        add_row(chk_row(16'd500, 1'b0, 1'b1,
            {1'b1, 16'd500, 1'b1, 1'b1, 16'd300, 17'd300, 17'd0}));
        // rate drops below the running count inside a scan
        add_row(cfg_row(CFG_DOWNSAMPLE_RATE, 16'd8));
        add_row(chk_row(16'd700, 1'b0, 1'b0, kept_res(16'd700)));
        add_row(smp_row(16'd900, 1'b0, 1'b0));
        add_row(smp_row(16'd400, 1'b0, 1'b0));
        add_row(cfg_row(CFG_DOWNSAMPLE_RATE, 16'd2));
        add_row(smp_row(16'd450, 1'b0, 1'b0));
        add_row(chk_row(16'd350, 1'b0, 1'b1,
            {1'b1, 16'd350, 1'b1, 1'b1, 16'd350, 17'd350, 17'd0}));
        // rate zero, empty rectangle
        add_row(cfg_row(CFG_DOWNSAMPLE_RATE, 16'd0));
        add_row(cfg_row(CFG_FORWARD_MIN, 16'd1000));
        add_row(cfg_row(CFG_FORWARD_MAX, 16'd300));
        add_row(chk_row(16'd600, 1'b0, 1'b0, kept_res(RANGE_INF)));
        add_row(chk_row(16'd600, 1'b0, 1'b1,
            {1'b1, RANGE_INF, 1'b1, 1'b0, RANGE_INF, 17'd0, 17'd0}));
        add_row(chk_row(16'hFFFF, 1'b1, 1'b0, kept_res(RANGE_INF)));

        foreach (dir_tab[n]) begin
            if (dir_tab[n].kind == ROW_CFG) begin
                if (!cfg_batch)
                    wait_idle();
                cfg_batch = 1'b1;
                write_reg(dir_tab[n].idx, dir_tab[n].data);
            end else begin
                cfg_batch = 1'b0;
                send_sample(dir_tab[n].range_mm, dir_tab[n].invalid, dir_tab[n].last,
                            dir_tab[n].typed, dir_tab[n].want);
            end
        end

        for (int p = 0; p < 10; p++) begin
            wait_idle();
            send_idle_pct = (p % 4 == 1) ? 50 : (p % 4 == 3) ? 15 : 0;
            stall_pct     = (p % 4 == 2) ? 50 : (p % 4 == 3) ? 15 : 0;
            if (p == 0) begin
                c_rate  = 16'd1;
                c_start = 16'h8000;
                c_step  = 16'hFFFF;
                c_fmin  = 16'h8000;
                c_fmax  = 16'h7FFF;
                c_hw    = 16'h7FFF;
            end else if (p == 1) begin
                c_rate  = 16'd255;
                c_start = 16'h7FFF;
                c_step  = 16'd0;
                c_fmin  = 16'd0;
                c_fmax  = 16'd0;
                c_hw    = 16'h8000;
            end else begin
                c_rate  = ($urandom_range(3) == 0) ? 16'($urandom_range(255))
                                                   : 16'($urandom_range(6));
                c_start = 16'($urandom);
                c_step  = ($urandom_range(1) == 0) ? 16'($urandom_range(400))
                                                   : 16'($urandom);
                lo      = int'($urandom_range(1500)) - 500;
                c_fmin  = 16'(lo);
                c_fmax  = 16'(lo + int'($urandom_range(2500)) - 200);
                c_hw    = ($urandom_range(4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(2000));
            end
            write_reg(CFG_DOWNSAMPLE_RATE, c_rate);
            write_reg(CFG_ANGLE_START, c_start);
            write_reg(CFG_ANGLE_STEP, c_step);
            write_reg(CFG_FORWARD_MIN, c_fmin);
            write_reg(CFG_FORWARD_MAX, c_fmax);
            write_reg(CFG_HALF_WIDTH, c_hw);
            repeat (85) send_random();
        end

        // long receiver hold-off with the sender running flat out
        wait_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(CFG_DOWNSAMPLE_RATE, 16'd1);
        hold_req = 1'b1;
        repeat (60) send_random();

        wait_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin : result_monitor
        t_roi_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_sample_kept, o_filtered_range_mm, o_summary_valid, o_obstacle_found,
                   o_nearest_range_mm, o_nearest_x_mm, o_nearest_y_mm};
            if (roi_results_due.size() == 0) begin
                $error("result transfer with nothing pending: filtered %0h summary %0b",
                       got.filtered, got.summary);
                mismatches++;
            end else begin
                want = roi_results_due.pop_front();
                check_field("sample_kept", 17'(want.kept), 17'(got.kept));
                check_field("filtered_range_mm", 17'(want.filtered), 17'(got.filtered));
                check_field("summary_valid", 17'(want.summary), 17'(got.summary));
                check_field("obstacle_found", 17'(want.obstacle), 17'(got.obstacle));
                check_field("nearest_range_mm", 17'(want.near_range), 17'(got.near_range));
                check_field("nearest_x_mm", want.near_x, got.near_x);
                check_field("nearest_y_mm", want.near_y, got.near_y);
            end
        end
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
`default_nettype wire
